[hw/rtl/dst_pkg.sv]
`default_nettype none

package dst_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int HANDLE_W        = 32;
  localparam int REQ_W           = 10;
  localparam int SLOT_OUT_W      = 6;
  localparam int COUNT_OUT_W     = 7;
  localparam int START_W         = 6;

  localparam logic [START_W-1:0] SEARCH_START_RST = 6'd2;

  typedef enum logic [1:0] {
    CMD_INSTALL    = 2'd0,
    CMD_INSTALL_AT = 2'd1,
    CMD_LOOKUP     = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO_HANDLE = 3'd1,
    ST_RANGE       = 3'd2,
    ST_OCCUPIED    = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/descriptor_slot_table_unit.sv]
`default_nettype none
// flow: zero-handle, range and full-by-config results strobe in the cycle after start;
//   install-at, lookup and remove go through the read and eval states; install scans
//   from search_start up to the last slot, one slot read per cycle
// throughput: one command at a time, busy until its result strobe is set up
// reset: synchronous clear pass writes every slot to empty, busy until it finishes
// results go out as a one-cycle strobe; the receiver cannot stall

module descriptor_slot_table_unit #(
  parameter int TABLE_SLOTS = dst_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_command,
  input  wire logic [dst_pkg::REQ_W-1:0]       in_slot_request,
  input  wire logic [dst_pkg::HANDLE_W-1:0]    in_handle_in,
  input  wire logic                            cfg_we,
  input  wire logic [dst_pkg::START_W-1:0]     cfg_wdata,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [dst_pkg::SLOT_OUT_W-1:0]       out_slot_index,
  output logic [dst_pkg::HANDLE_W-1:0]         out_handle_out,
  output logic [dst_pkg::COUNT_OUT_W-1:0]      out_occupied_count
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  logic [dst_pkg::START_W-1:0]  search_start_r;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [dst_pkg::HANDLE_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [dst_pkg::HANDLE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_start_r <= dst_pkg::SEARCH_START_RST;
    end else if (cfg_we) begin
      search_start_r <= cfg_wdata;
    end
  end

  dst_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  dst_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_slot_request    (in_slot_request),
    .in_handle_in       (in_handle_in),
    .search_start       (search_start_r),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_handle_out     (out_handle_out),
    .out_occupied_count (out_occupied_count)
  );

  // every accepted command either strobes next or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command left no trace");

  // failed commands never change the count
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == dst_pkg::ST_ZERO_HANDLE ||
                   out_status == dst_pkg::ST_RANGE ||
                   out_status == dst_pkg::ST_OCCUPIED ||
                   out_status == dst_pkg::ST_FULL)) |-> $stable(out_occupied_count))
    else $error("count moved on a failed command");

  // full table reports no slot and no handle
  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == dst_pkg::ST_FULL) |->
      (out_slot_index == '0 && out_handle_out == '0))
    else $error("full result carries slot or handle");

  // meant to catch a result strobe during the clear pass; the consequent holds whenever busy does
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy) && !$past(out_valid) && !$past(start)) |-> !out_valid || busy)
    else $error("result strobe outside a command");

endmodule

`default_nettype wire

[hw/rtl/dst_mem.sv]
`default_nettype none

module dst_mem #(
  parameter int DEPTH = dst_pkg::TABLE_SLOTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [dst_pkg::HANDLE_W-1:0] wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [dst_pkg::HANDLE_W-1:0] rdata_r
);

  logic [dst_pkg::HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/dst_ctrl.sv]
`default_nettype none

module dst_ctrl #(
  parameter int TABLE_SLOTS = dst_pkg::TABLE_SLOTS_DEF,
  parameter int AW          = $clog2(TABLE_SLOTS),
  parameter int CW          = $clog2(TABLE_SLOTS + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_command,
  input  wire logic [dst_pkg::REQ_W-1:0]       in_slot_request,
  input  wire logic [dst_pkg::HANDLE_W-1:0]    in_handle_in,
  input  wire logic [dst_pkg::START_W-1:0]     search_start,
  output logic                                 mem_we,
  output logic [AW-1:0]                        mem_waddr,
  output logic [dst_pkg::HANDLE_W-1:0]         mem_wdata,
  output logic [AW-1:0]                        mem_raddr,
  input  wire logic [dst_pkg::HANDLE_W-1:0]    mem_rdata,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [dst_pkg::SLOT_OUT_W-1:0]       out_slot_index,
  output logic [dst_pkg::HANDLE_W-1:0]         out_handle_out,
  output logic [dst_pkg::COUNT_OUT_W-1:0]      out_occupied_count
);

  localparam int SlotOutW  = dst_pkg::SLOT_OUT_W;
  localparam int CountOutW = dst_pkg::COUNT_OUT_W;
  localparam int ReqW      = dst_pkg::REQ_W;
  localparam int CurW      = AW + 1;

  localparam logic [ReqW:0]   SLOTS_REQ = (ReqW + 1)'(TABLE_SLOTS);
  localparam logic [CurW-1:0] SLOTS_CUR = CurW'(TABLE_SLOTS);
  localparam logic [CurW-1:0] CUR_ONE   = CurW'(1);
  localparam logic [AW-1:0]   LAST_IDX  = AW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0]   CNT_ONE   = CW'(1);
  localparam logic [ReqW-ReqW+4:0] START_PAD = '0;

  dst_pkg::state_t  state_r, state_nxt;
  dst_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [ReqW-1:0]  req_r, req_nxt;
  logic [dst_pkg::HANDLE_W-1:0] handle_r, handle_nxt;
  logic [CurW-1:0]  cursor_r, cursor_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  dst_pkg::status_t status_r, status_nxt;
  logic [SlotOutW-1:0] slot_r, slot_nxt;
  logic [dst_pkg::HANDLE_W-1:0] hout_r, hout_nxt;

  logic in_range;
  logic start_ok;
  logic rdata_zero;

  assign in_range   = {1'b0, in_slot_request} < SLOTS_REQ;
  assign start_ok   = {START_PAD, search_start} < SLOTS_REQ;
  assign rdata_zero = (mem_rdata == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dst_pkg::S_CLEAR;
      cursor_r    <= '0;
      chk_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      chk_vld_r   <= chk_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    req_r     <= req_nxt;
    handle_r  <= handle_nxt;
    chk_idx_r <= chk_idx_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    hout_r    <= hout_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    req_nxt       = req_r;
    handle_nxt    = handle_r;
    cursor_nxt    = cursor_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    hout_nxt      = hout_r;
    mem_we        = 1'b0;
    mem_waddr     = cursor_r[AW-1:0];
    mem_wdata     = '0;
    mem_raddr     = cursor_r[AW-1:0];

    unique case (state_r)
      dst_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (cursor_r == SLOTS_CUR - CUR_ONE) begin
          cursor_nxt = '0;
          state_nxt  = dst_pkg::S_IDLE;
        end else begin
          cursor_nxt = cursor_r + CUR_ONE;
        end
      end

      dst_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt    = dst_pkg::cmd_t'(in_command);
          req_nxt    = in_slot_request;
          handle_nxt = in_handle_in;
          hout_nxt   = '0;
          if (dst_pkg::cmd_t'(in_command) == dst_pkg::CMD_INSTALL) begin
            slot_nxt = '0;
            if (in_handle_in == '0) begin
              status_nxt    = dst_pkg::ST_ZERO_HANDLE;
              out_valid_nxt = 1'b1;
            end else if (!start_ok) begin
              status_nxt    = dst_pkg::ST_FULL;
              out_valid_nxt = 1'b1;
            end else begin
              cursor_nxt = CurW'(search_start);
              state_nxt  = dst_pkg::S_SCAN;
            end
          end else begin
            slot_nxt = SlotOutW'(in_slot_request);
            if (dst_pkg::cmd_t'(in_command) == dst_pkg::CMD_INSTALL_AT &&
                in_handle_in == '0) begin
              status_nxt    = dst_pkg::ST_ZERO_HANDLE;
              out_valid_nxt = 1'b1;
            end else if (!in_range) begin
              status_nxt    = dst_pkg::ST_RANGE;
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = dst_pkg::S_READ;
            end
          end
        end
      end

      dst_pkg::S_READ: begin
        mem_raddr = req_r[AW-1:0];
        state_nxt = dst_pkg::S_EVAL;
      end

      dst_pkg::S_EVAL: begin
        mem_waddr     = req_r[AW-1:0];
        out_valid_nxt = 1'b1;
        status_nxt    = dst_pkg::ST_OK;
        state_nxt     = dst_pkg::S_IDLE;
        unique case (cmd_r)
          dst_pkg::CMD_INSTALL_AT: begin
            if (!rdata_zero) begin
              status_nxt = dst_pkg::ST_OCCUPIED;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = handle_r;
              count_nxt = count_r + CNT_ONE;
            end
          end
          dst_pkg::CMD_LOOKUP: begin
            hout_nxt = mem_rdata;
          end
          dst_pkg::CMD_REMOVE: begin
            hout_nxt = mem_rdata;
            if (!rdata_zero) begin
              mem_we    = 1'b1;
              count_nxt = count_r - CNT_ONE;
            end
          end
          default: begin
            hout_nxt = '0;
          end
        endcase
      end

      dst_pkg::S_SCAN: begin
        if (chk_vld_r && rdata_zero) begin
          mem_we        = 1'b1;
          mem_waddr     = chk_idx_r;
          mem_wdata     = handle_r;
          count_nxt     = count_r + CNT_ONE;
          status_nxt    = dst_pkg::ST_OK;
          slot_nxt      = SlotOutW'(chk_idx_r);
          out_valid_nxt = 1'b1;
          state_nxt     = dst_pkg::S_IDLE;
        end else if (chk_vld_r && chk_idx_r == LAST_IDX) begin
          status_nxt    = dst_pkg::ST_FULL;
          slot_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = dst_pkg::S_IDLE;
        end else if (cursor_r < SLOTS_CUR) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cursor_r[AW-1:0];
          cursor_nxt  = cursor_r + CUR_ONE;
        end
      end

      default: begin
        state_nxt = dst_pkg::S_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != dst_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot_index     = slot_r;
  assign out_handle_out     = hout_r;
  assign out_occupied_count = CountOutW'(count_r);

endmodule

`default_nettype wire
